FILE: rtl/core/idp_pkg.sv
package idp_pkg;

  localparam int unsigned NumChars   = 10;
  localparam int unsigned CharW      = 8;
  localparam int unsigned InDataW    = NumChars * CharW;
  localparam int unsigned YearW      = 14;
  localparam int unsigned MonthW     = 7;
  localparam int unsigned DayW       = 7;
  localparam int unsigned DayNumW    = 22;
  localparam int unsigned PldW       = 12;
  localparam int unsigned OutDataW   = 56;

  localparam logic [CharW-1:0] HyphenChar = 8'h2D;
  localparam logic [CharW-1:0] DigitZero  = 8'h30;
  localparam logic [CharW-1:0] DigitNine  = 8'h39;
  localparam logic [4:0]       LeapFebDays = 5'd29;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FORMAT = 2'd1,
    ST_RANGE  = 2'd2
  } status_e;

  // Parsed characters, first stage output
  typedef struct packed {
    logic              fmt_ok;
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [6:0]        cent;   // year / 100
    logic [6:0]        yrem;   // year % 100
  } dec_t;

  // Checked date with partial day count, second stage output
  typedef struct packed {
    status_e           status;
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [DayNumW-1:0] y365;
    logic [PldW-1:0]   pld;
    logic              leap;
  } cal_t;

  typedef struct packed {
    status_e            status;
    logic [DayNumW-1:0] day_number;
    logic [DayW-1:0]    day;
    logic [MonthW-1:0]  month;
    logic [YearW-1:0]   year;
  } res_t;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the months before month m of a common year
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/core/iso_date_parse_to_day_number.sv
// Parses a ten-character YYYY-MM-DD date and returns a status in tuser
// (valid, format error, month or day out of range) together with year, month,
// day and the day number counted from year 0. The block is a three-stage
// pipeline (character decode, calendar check with year*365 and prior leap days,
// final day sum), so a result passes the decode, calendar and total registers
// in turn, and one date can be taken every cycle while the output is not held
// off. Each stage holds its own valid bit and is refilled whenever it is
// empty or its successor takes its item, so back pressure on the output stalls
// only as far as the pipeline is full.
module iso_date_parse_to_day_number import idp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // char_0 .. char_9, 8 bits each
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // year_value[13:0], month_value[20:14], day_value[27:21],
  // day_number[49:28], zero fill[55:50]
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // status
  output logic [1:0]          m_axis_tuser_o
);

  logic dec_valid, dec_ready;
  logic cal_valid, cal_ready;
  dec_t dec;
  cal_t cal;
  res_t res;

  idp_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .data_i  (s_axis_tdata_i),
    .valid_o (dec_valid),
    .ready_i (dec_ready),
    .dec_o   (dec)
  );

  idp_calendar u_calendar (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .ready_o (dec_ready),
    .dec_i   (dec),
    .valid_o (cal_valid),
    .ready_i (cal_ready),
    .cal_o   (cal)
  );

  idp_total u_total (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cal_valid),
    .ready_o (cal_ready),
    .cal_i   (cal),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (res)
  );

  assign m_axis_tuser_o = res.status;
  assign m_axis_tdata_o = {6'd0, res.day_number, res.day, res.month, res.year};

  // A valid date always lands on a nonzero day number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res.status == ST_OK |-> res.day_number != '0)
    else $error("valid date with zero day number");

  // Rejected dates carry no day number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res.status != ST_OK |-> res.day_number == '0)
    else $error("day number on rejected date");

  // Format errors clear the parsed fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res.status == ST_FORMAT |->
      res.year == '0 && res.month == '0 && res.day == '0)
    else $error("parsed fields kept on format error");

endmodule

FILE: rtl/core/idp_decode.sv
module idp_decode import idp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [InDataW-1:0] data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output dec_t               dec_o
);

  logic       valid_q;
  dec_t       dec_d, dec_q;
  logic [3:0] dv [NumChars];
  logic       chars_ok;

  always_comb begin
    logic [CharW-1:0] c;
    chars_ok = 1'b1;
    for (int k = 0; k < NumChars; k++) begin
      c = data_i[k*CharW +: CharW];
      dv[k] = c[3:0];
      if (k == 4 || k == 7) begin
        if (c != HyphenChar) chars_ok = 1'b0;
      end else begin
        if (!(c inside {[DigitZero:DigitNine]})) chars_ok = 1'b0;
      end
    end
  end

  always_comb begin
    dec_d.fmt_ok = chars_ok;
    dec_d.cent   = 7'(dv[0]) * 7'd10 + 7'(dv[1]);
    dec_d.yrem   = 7'(dv[2]) * 7'd10 + 7'(dv[3]);
    dec_d.year   = 14'(dv[0]) * 14'd1000 + 14'(dv[1]) * 14'd100
                 + 14'(dv[2]) * 14'd10 + 14'(dv[3]);
    dec_d.month  = 7'(dv[5]) * 7'd10 + 7'(dv[6]);
    dec_d.day    = 7'(dv[8]) * 7'd10 + 7'(dv[9]);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      dec_q <= dec_d;
    end
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;

endmodule

FILE: rtl/core/idp_calendar.sv
module idp_calendar import idp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  dec_t dec_i,
  output logic valid_o,
  input  logic ready_i,
  output cal_t cal_o
);

  logic             valid_q;
  cal_t             cal_d, cal_q;
  logic             leap;
  logic             month_ok;
  logic             day_ok;
  logic [4:0]       maxd;
  logic [YearW-1:0] prev_year;
  logic [6:0]       q100;
  logic [4:0]       q400;

  // Leap rules from the century and year-in-century digit pairs
  assign leap = (dec_i.yrem != 7'd0) ? (dec_i.yrem[1:0] == 2'd0)
                                     : (dec_i.cent[1:0] == 2'd0);

  assign month_ok = (dec_i.month >= 7'd1) && (dec_i.month <= 7'd12);
  assign maxd = (dec_i.month == 7'd2 && leap) ? LeapFebDays
                                              : month_len(dec_i.month[3:0]);
  assign day_ok = (dec_i.day != 7'd0) && (dec_i.day <= {2'b00, maxd});

  // Leap days of years 1 .. year-1: p/4 - p/100 + p/400 with p = year-1
  assign prev_year = dec_i.year - 14'd1;
  assign q100 = (dec_i.yrem != 7'd0) ? dec_i.cent : dec_i.cent - 7'd1;
  assign q400 = q100[6:2];

  always_comb begin
    cal_d.leap  = leap;
    cal_d.y365  = 22'(dec_i.year) * 22'd365;
    cal_d.pld   = (dec_i.year == 14'd0) ? 12'd0
                : prev_year[13:2] - 12'(q100) + 12'(q400);
    cal_d.year  = dec_i.year;
    cal_d.month = dec_i.month;
    cal_d.day   = dec_i.day;
    if (!dec_i.fmt_ok) begin
      cal_d.status = ST_FORMAT;
      cal_d.year   = '0;
      cal_d.month  = '0;
      cal_d.day    = '0;
    end else if (!month_ok || !day_ok) begin
      cal_d.status = ST_RANGE;
    end else begin
      cal_d.status = ST_OK;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      cal_q <= cal_d;
    end
  end

  assign valid_o = valid_q;
  assign cal_o   = cal_q;

endmodule

FILE: rtl/core/idp_total.sv
module idp_total import idp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  cal_t cal_i,
  output logic valid_o,
  input  logic ready_i,
  output res_t res_o
);

  logic               valid_q;
  res_t               res_d, res_q;
  logic [DayNumW-1:0] total;
  logic               feb_extra;

  // Count this year's Feb 29 once the date is past February
  assign feb_extra = cal_i.leap && (cal_i.month > 7'd2);

  assign total = cal_i.y365 + 22'(cal_i.pld) + 22'(days_before(cal_i.month[3:0]))
               + 22'(feb_extra) + 22'(cal_i.day);

  always_comb begin
    res_d.status     = cal_i.status;
    res_d.year       = cal_i.year;
    res_d.month      = cal_i.month;
    res_d.day        = cal_i.day;
    res_d.day_number = (cal_i.status == ST_OK) ? total : '0;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

FILE: tb/sv/iso_date_parse_to_day_number_tb.sv
`timescale 1ns / 100ps

module iso_date_parse_to_day_number_tb;
  import idp_pkg::*;

  localparam int unsigned RandomItems = 1625;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned NumDirected = 25;
  localparam int unsigned MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    status_e            status;
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
    logic [DayNumW-1:0] day_number;
  } date_result_t;

  // text holds the date as written, first character in the top byte
  typedef struct packed {
    logic [InDataW-1:0] text;
    logic               typed;
    date_result_t       want;
  } date_row_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  // char_0 .. char_9, 8 bits each
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  // year_value, month_value, day_value, day_number, zero fill
  logic [OutDataW-1:0] m_axis_tdata_o;
  // status
  logic [1:0]          m_axis_tuser_o;

  date_result_t pending_dates [$];
  int unsigned  mismatch_count = 0;
  int unsigned  idle_cycles    = 0;
  int unsigned  burst_left     = 0;
  int unsigned  hold_requests  = 0;
  int unsigned  holds_served   = 0;
  int unsigned  hold_left      = 0;
  logic [7:0]   rx_phase       = '0;
  int unsigned  rx_mode        = 0;

  date_row_t date_rows [NumDirected] = '{
    '{"0000-01-01", 1'b1, '{ST_OK,     14'd0,    7'd1,  7'd1,  22'd1}},
    '{"9999-12-31", 1'b1, '{ST_OK,     14'd9999, 7'd12, 7'd31, 22'd3652424}},
    '{"0000-02-29", 1'b1, '{ST_OK,     14'd0,    7'd2,  7'd29, 22'd60}},
    '{"1900-02-29", 1'b1, '{ST_RANGE,  14'd1900, 7'd2,  7'd29, 22'd0}},
    '{"2023-02-29", 1'b1, '{ST_RANGE,  14'd2023, 7'd2,  7'd29, 22'd0}},
    '{"2000-02-29", 1'b0, '0},
    '{"0400-02-29", 1'b0, '0},
    '{"2024-13-01", 1'b1, '{ST_RANGE,  14'd2024, 7'd13, 7'd1,  22'd0}},
    '{"2024-00-10", 1'b1, '{ST_RANGE,  14'd2024, 7'd0,  7'd10, 22'd0}},
    '{"2024-01-00", 1'b1, '{ST_RANGE,  14'd2024, 7'd1,  7'd0,  22'd0}},
    '{"2024-04-31", 1'b1, '{ST_RANGE,  14'd2024, 7'd4,  7'd31, 22'd0}},
    '{"2024-99-99", 1'b1, '{ST_RANGE,  14'd2024, 7'd99, 7'd99, 22'd0}},
    '{"0000-00-00", 1'b1, '{ST_RANGE,  14'd0,    7'd0,  7'd0,  22'd0}},
    '{"2024/01-01", 1'b1, '{ST_FORMAT, 14'd0,    7'd0,  7'd0,  22'd0}},
    '{"2024-01/01", 1'b1, '{ST_FORMAT, 14'd0,    7'd0,  7'd0,  22'd0}},
    '{"20a4-01-01", 1'b1, '{ST_FORMAT, 14'd0,    7'd0,  7'd0,  22'd0}},
    '{"2024-01-0:", 1'b1, '{ST_FORMAT, 14'd0,    7'd0,  7'd0,  22'd0}},
    '{"/024-01-01", 1'b1, '{ST_FORMAT, 14'd0,    7'd0,  7'd0,  22'd0}},
    '{{10{8'hFF}},  1'b1, '{ST_FORMAT, 14'd0,    7'd0,  7'd0,  22'd0}},
    '{{10{8'h00}},  1'b1, '{ST_FORMAT, 14'd0,    7'd0,  7'd0,  22'd0}},
    '{"0001-01-01", 1'b0, '0},
    '{"0004-03-01", 1'b0, '0},
    '{"2100-03-01", 1'b0, '0},
    '{"2024-12-31", 1'b0, '0},
    '{"1999-06-15", 1'b0, '0}
  };

  iso_date_parse_to_day_number uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #4 clk_i = ~clk_i;

  // Reverse the byte order so that the first character lands in char_0
  function automatic logic [InDataW-1:0] chars_from_text(input logic [InDataW-1:0] text);
    logic [InDataW-1:0] chars;
    for (int k = 0; k < NumChars; k++) begin
      chars[k*CharW +: CharW] = text[(NumChars-1-k)*CharW +: CharW];
    end
    return chars;
  endfunction

  function automatic bit is_leap(input int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
    if (m == 2 && is_leap(y)) begin
      return 29;
    end
    return MonthDays[m-1];
  endfunction

  function automatic int unsigned digit_at(input logic [InDataW-1:0] chars, input int k);
    return int'(chars[k*CharW +: CharW] - DigitZero);
  endfunction

  function automatic date_result_t predict_date(input logic [InDataW-1:0] chars);
    date_result_t r;
    logic [7:0]   ch;
    bit           fmt_ok;
    int unsigned  y, mo, dy, total, prior;
    r = '0;
    fmt_ok = 1'b1;
    for (int k = 0; k < NumChars; k++) begin
      ch = chars[k*CharW +: CharW];
      if (k == 4 || k == 7) begin
        if (ch != HyphenChar) fmt_ok = 1'b0;
      end else if (ch < DigitZero || ch > DigitNine) begin
        fmt_ok = 1'b0;
      end
    end
    if (!fmt_ok) begin
      r.status = ST_FORMAT;
      return r;
    end
    y  = digit_at(chars, 0) * 1000 + digit_at(chars, 1) * 100
       + digit_at(chars, 2) * 10 + digit_at(chars, 3);
    mo = digit_at(chars, 5) * 10 + digit_at(chars, 6);
    dy = digit_at(chars, 8) * 10 + digit_at(chars, 9);
    r.year  = YearW'(y);
    r.month = MonthW'(mo);
    r.day   = DayW'(dy);
    if (mo < 1 || mo > 12 || dy < 1 || dy > month_length(y, mo)) begin
      r.status = ST_RANGE;
      return r;
    end
    // leap days of years 1 .. y-1; none when y is 0
    prior = (y == 0) ? 0 : (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400;
    total = y * 365 + prior + dy;
    for (int m = 1; m < mo; m++) begin
      total += month_length(y, m);
    end
    r.status     = ST_OK;
    r.day_number = DayNumW'(total);
    return r;
  endfunction

  function automatic logic [InDataW-1:0] date_chars(input int unsigned y, input int unsigned m,
                                                    input int unsigned d);
    logic [InDataW-1:0] v;
    v[0*CharW +: CharW] = DigitZero + 8'((y / 1000) % 10);
    v[1*CharW +: CharW] = DigitZero + 8'((y / 100) % 10);
    v[2*CharW +: CharW] = DigitZero + 8'((y / 10) % 10);
    v[3*CharW +: CharW] = DigitZero + 8'(y % 10);
    v[4*CharW +: CharW] = HyphenChar;
    v[5*CharW +: CharW] = DigitZero + 8'((m / 10) % 10);
    v[6*CharW +: CharW] = DigitZero + 8'(m % 10);
    v[7*CharW +: CharW] = HyphenChar;
    v[8*CharW +: CharW] = DigitZero + 8'((d / 10) % 10);
    v[9*CharW +: CharW] = DigitZero + 8'(d % 10);
    return v;
  endfunction

  // Mostly well-formed dates, then range errors, corrupted characters and raw noise
  function automatic logic [InDataW-1:0] random_date_chars();
    int unsigned        sel, y, m, d;
    logic [InDataW-1:0] v;
    sel = $urandom_range(99);
    y = $urandom_range(9999);
    if ($urandom_range(7) == 0) y = 100 * $urandom_range(99);
    m = $urandom_range(1, 12);
    if (m == 2 && $urandom_range(3) == 0) d = month_length(y, 2);
    else d = $urandom_range(1, month_length(y, m));
    if (sel < 70) begin
      return date_chars(y, m, d);
    end else if (sel < 82) begin
      case ($urandom_range(3))
        0:       m = $urandom_range(13, 99);
        1:       m = 0;
        2:       d = 0;
        default: d = $urandom_range(month_length(y, m) + 1, 99);
      endcase
      return date_chars(y, m, d);
    end else if (sel < 94) begin
      v = date_chars(y, m, d);
      v[$urandom_range(NumChars-1)*CharW +: CharW] = 8'($urandom);
      return v;
    end
    v = InDataW'({$urandom, $urandom, $urandom});
    return v;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_date_result();
    date_result_t want;
    if (pending_dates.size() == 0) begin
      report_mismatch("result with nothing pending, tdata", m_axis_tdata_o, 0);
    end else begin
      want = pending_dates.pop_front();
      if (m_axis_tuser_o != want.status)
        report_mismatch("status", m_axis_tuser_o, want.status);
      if (m_axis_tdata_o[13:0] != want.year)
        report_mismatch("year_value", m_axis_tdata_o[13:0], want.year);
      if (m_axis_tdata_o[20:14] != want.month)
        report_mismatch("month_value", m_axis_tdata_o[20:14], want.month);
      if (m_axis_tdata_o[27:21] != want.day)
        report_mismatch("day_value", m_axis_tdata_o[27:21], want.day);
      if (m_axis_tdata_o[49:28] != want.day_number)
        report_mismatch("day_number", m_axis_tdata_o[49:28], want.day_number);
    end
  endtask

  // Offer one date and hold it until the transfer
  task automatic send_date(input logic [InDataW-1:0] chars, input bit typed,
                           input date_result_t want);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= chars;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_dates.push_back(typed ? want : predict_date(chars));
  endtask

  // Close a burst with a random gap, then pick the next burst length
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = $urandom_range(1, 6);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_pending();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_dates.size() != 0);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (date_rows[i]) begin
      send_date(chars_from_text(date_rows[i].text), date_rows[i].typed, date_rows[i].want);
      pace_sender();
    end
    drain_pending();
    for (int n = 0; n < RandomItems; n++) begin
      // keep offering back to back while the receiver holds off
      if (n == 0 || n == 900) begin
        hold_requests <= hold_requests + 1;
        burst_left = 60;
      end
      if (n == 500) drain_pending();
      send_date(random_date_chars(), 1'b0, '0);
      pace_sender();
    end
    drain_pending();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (holds_served != hold_requests) begin
      holds_served    <= hold_requests;
      hold_left       <= HoldCycles;
      m_axis_tready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      rx_phase <= rx_phase + 1'b1;
      if (rx_phase[5:0] == 0) rx_mode <= $urandom_range(3);
      case (rx_mode)
        0:       m_axis_tready_i <= 1'b1;
        1:       m_axis_tready_i <= 1'($urandom_range(1));
        2:       m_axis_tready_i <= (rx_phase[1:0] != 2'd0);
        default: m_axis_tready_i <= ($urandom_range(7) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) check_date_result();
      if (idle_cycles >= IdleLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

endmodule
